[rtl/sprg_pkg.sv]
// ----------------------------------------------------------------------------
// sprg_pkg
// Shared types and constants for the servo pulse ramp generator.
// ----------------------------------------------------------------------------
package sprg_pkg;

    // Timing of the servo frame
    localparam int FRAME_MS      = 20;
    localparam int NEUTRAL_PULSE = 1500;

    // Field widths
    localparam int CHAN_W  = 8;
    localparam int REQ_W   = 16;
    localparam int DUR_W   = 16;
    localparam int PW_W    = 15;
    localparam int STEPS_W = 12;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 16;

    localparam int STEPS_MAX = (1 << STEPS_W) - 1;

    // Serial divider: dividend holds |delta| * index (15 + 12 bits)
    localparam int DIV_W     = PW_W + STEPS_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Stream packing
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 24;

    // Item kinds on s_tuser
    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_CHANNEL_ID   = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_MIN_PULSE    = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_MAX_PULSE    = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_MIN_DURATION = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_MAX_DURATION = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEPS,
        ST_ADV,
        ST_MUL,
        ST_RDIV,
        ST_DONE
    } sprg_state_t;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [STEPS_W-1:0] divisor;
    } sprg_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } sprg_div_rsp_t;

endpackage

[rtl/sprg_serdiv.sv]
// ----------------------------------------------------------------------------
// sprg_serdiv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module sprg_serdiv (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sprg_pkg::sprg_div_req_t req,
    output sprg_pkg::sprg_div_rsp_t rsp
);
    import sprg_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [STEPS_W-1:0]   rem_reg, rem_next;
    logic [STEPS_W-1:0]   dvs_reg, dvs_next;

    logic [STEPS_W:0]     shifted;
    logic                 ge;

    // Partial remainder with the next dividend bit shifted in
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? STEPS_W'(shifted - {1'b0, dvs_reg}) : shifted[STEPS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/servo_pulse_ramp_generator.sv]
// ----------------------------------------------------------------------------
// servo_pulse_ramp_generator
// Servo pulse-width ramp generator with command validation and frame ticks.
// ----------------------------------------------------------------------------
// One item is handled at a time and each gives one result item. A tick while
// disabled or a rejected command goes straight from the check to its result.
// An accepted command first works out its step count; the first one also
// takes a ramp step, as does every tick while enabled. The step count comes
// from the bit-serial restoring divider (one quotient bit per cycle, 27 bits);
// a ramp step runs the shift-add multiplier (one bit of the step index per
// cycle) and then the divider. A new item is accepted while the previous
// result still waits on the output register.
module servo_pulse_ramp_generator (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [sprg_pkg::CFG_A_W-1:0]    cfg_addr,
    input  logic [sprg_pkg::CFG_D_W-1:0]    cfg_wdata,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // channel[7:0], requested_pulse[23:8], duration[39:24], count_at_tick[54:40]
    input  logic [sprg_pkg::S_DATA_W-1:0]   s_tdata,
    // cmd[0]
    input  logic                            s_tuser,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // accepted[0], pulse_width[15:1], pin_high[16], active[17]
    output logic [sprg_pkg::M_DATA_W-1:0]   m_tdata
);
    import sprg_pkg::*;

    // Configuration registers
    logic [CHAN_W-1:0] channel_id_reg;
    logic [PW_W-1:0]   min_pulse_reg;
    logic [PW_W-1:0]   max_pulse_reg;
    logic [DUR_W-1:0]  min_dur_reg;
    logic [DUR_W-1:0]  max_dur_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_id_reg <= '0;
            min_pulse_reg  <= PW_W'(500);
            max_pulse_reg  <= PW_W'(2500);
            min_dur_reg    <= '0;
            max_dur_reg    <= '1;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_CHANNEL_ID:   channel_id_reg <= cfg_wdata[CHAN_W-1:0];
                REG_MIN_PULSE:    min_pulse_reg  <= cfg_wdata[PW_W-1:0];
                REG_MAX_PULSE:    max_pulse_reg  <= cfg_wdata[PW_W-1:0];
                REG_MIN_DURATION: min_dur_reg    <= cfg_wdata[DUR_W-1:0];
                REG_MAX_DURATION: max_dur_reg    <= cfg_wdata[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, item and ramp state
    sprg_state_t        state_reg, state_next;

    logic               cmd_reg, cmd_next;
    logic [CHAN_W-1:0]  chan_reg, chan_next;
    logic [REQ_W-1:0]   req_reg, req_next;
    logic [DUR_W-1:0]   dur_reg, dur_next;
    logic [PW_W-1:0]    cnt_reg, cnt_next;

    logic               acc_reg, acc_next;
    logic               first_reg, first_next;
    logic               tick_adv_reg, tick_adv_next;

    logic               enabled_reg, enabled_next;
    logic [PW_W-1:0]    cur_w_reg, cur_w_next;
    logic [PW_W-1:0]    start_reg, start_next;
    logic [PW_W-1:0]    target_reg, target_next;
    logic [STEPS_W-1:0] steps_reg, steps_next;
    logic [STEPS_W-1:0] index_reg, index_next;

    // Shift-add multiplier
    logic [DIV_W-1:0]   mcand_reg, mcand_next;
    logic [STEPS_W-1:0] mplier_reg, mplier_next;
    logic [DIV_W-1:0]   prod_reg, prod_next;
    logic               neg_reg, neg_next;

    // Output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    sprg_div_req_t      div_req;
    sprg_div_rsp_t      div_rsp;

    sprg_serdiv u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Command validation
    logic cmd_valid;
    assign cmd_valid = (chan_reg == channel_id_reg)
                    && (req_reg >= {1'b0, min_pulse_reg})
                    && (req_reg <= {1'b0, max_pulse_reg})
                    && (dur_reg >= min_dur_reg)
                    && (dur_reg <= max_dur_reg);

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    // Ramp arithmetic helpers
    logic signed [PW_W:0]   delta;
    logic [PW_W-1:0]        delta_mag;
    logic [STEPS_W-1:0]     steps_sat;
    logic signed [PW_W+1:0] ramp_sum;
    logic [PW_W-1:0]        ramp_w;

    assign delta     = $signed({1'b0, target_reg}) - $signed({1'b0, start_reg});
    assign delta_mag = delta[PW_W] ? PW_W'(-delta) : delta[PW_W-1:0];
    assign steps_sat = (div_rsp.quotient[DIV_W-1:STEPS_W] != '0)
                     ? STEPS_W'(STEPS_MAX) : div_rsp.quotient[STEPS_W-1:0];

    // Quotient is at most |delta|, so 15 bits hold it
    always_comb begin
        logic signed [PW_W+1:0] q;
        q = $signed({2'b0, div_rsp.quotient[PW_W-1:0]});
        ramp_sum = neg_reg ? ($signed({2'b0, start_reg}) - q)
                           : ($signed({2'b0, start_reg}) + q);
        if (ramp_sum < $signed({2'b0, min_pulse_reg})) begin
            ramp_w = min_pulse_reg;
        end else if (ramp_sum > $signed({2'b0, max_pulse_reg})) begin
            ramp_w = max_pulse_reg;
        end else begin
            ramp_w = ramp_sum[PW_W-1:0];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_CHECK;
            ST_CHECK: begin
                if (cmd_reg == CMD_TICK) begin
                    state_next = enabled_reg ? ST_ADV : ST_DONE;
                end else begin
                    state_next = cmd_valid ? ST_STEPS : ST_DONE;
                end
            end
            ST_STEPS: if (div_rsp.done) state_next = enabled_reg ? ST_DONE : ST_ADV;
            ST_ADV:   state_next = (index_reg < steps_reg) ? ST_MUL : ST_DONE;
            ST_MUL:   if (mplier_reg == '0) state_next = ST_RDIV;
            ST_RDIV:  if (div_rsp.done) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Divider requests: step count on an accepted command, ramp point on a step
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = steps_reg;
        if (state_reg == ST_CHECK) begin
            div_req.start    = (cmd_reg == CMD_MOVE) && cmd_valid;
            div_req.dividend = DIV_W'({1'b0, dur_reg} + (DUR_W + 1)'(FRAME_MS - 1));
            div_req.divisor  = STEPS_W'(FRAME_MS);
        end else if (state_reg == ST_MUL) begin
            div_req.start = (mplier_reg == '0);
        end
    end

    // Datapath updates
    always_comb begin
        cmd_next      = cmd_reg;
        chan_next     = chan_reg;
        req_next      = req_reg;
        dur_next      = dur_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        first_next    = first_reg;
        tick_adv_next = tick_adv_reg;
        enabled_next  = enabled_reg;
        cur_w_next    = cur_w_reg;
        start_next    = start_reg;
        target_next   = target_reg;
        steps_next    = steps_reg;
        index_next    = index_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        prod_next     = prod_reg;
        neg_next      = neg_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next      = s_tuser;
                    chan_next     = s_tdata[7:0];
                    req_next      = s_tdata[23:8];
                    dur_next      = s_tdata[39:24];
                    cnt_next      = s_tdata[54:40];
                    acc_next      = 1'b0;
                    first_next    = 1'b0;
                    tick_adv_next = 1'b0;
                end
            end
            ST_CHECK: begin
                if (cmd_reg == CMD_TICK) begin
                    tick_adv_next = enabled_reg;
                end else begin
                    acc_next = cmd_valid;
                end
            end
            ST_STEPS: begin
                if (div_rsp.done) begin
                    steps_next  = steps_sat;
                    index_next  = '0;
                    start_next  = cur_w_reg;
                    target_next = req_reg[PW_W-1:0];
                    if (!enabled_reg) begin
                        enabled_next = 1'b1;
                        first_next   = 1'b1;
                    end
                end
            end
            ST_ADV: begin
                if (index_reg < steps_reg) begin
                    index_next  = index_reg + 1'b1;
                    mcand_next  = DIV_W'(delta_mag);
                    mplier_next = index_reg + 1'b1;
                    prod_next   = '0;
                    neg_next    = delta[PW_W];
                end else begin
                    cur_w_next = target_reg;
                end
            end
            ST_MUL: begin
                if (mplier_reg != '0) begin
                    if (mplier_reg[0]) prod_next = prod_reg + mcand_reg;
                    mcand_next  = {mcand_reg[DIV_W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[STEPS_W-1:1]};
                end
            end
            ST_RDIV: begin
                if (div_rsp.done) cur_w_next = ramp_w;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0,
                                     enabled_reg,
                                     first_reg | (tick_adv_reg & (cnt_reg < cur_w_reg)),
                                     cur_w_reg,
                                     acc_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            enabled_reg  <= 1'b0;
            cur_w_reg    <= PW_W'(NEUTRAL_PULSE);
            start_reg    <= PW_W'(NEUTRAL_PULSE);
            target_reg   <= PW_W'(NEUTRAL_PULSE);
            steps_reg    <= '0;
            index_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            enabled_reg  <= enabled_next;
            cur_w_reg    <= cur_w_next;
            start_reg    <= start_next;
            target_reg   <= target_next;
            steps_reg    <= steps_next;
            index_reg    <= index_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg      <= cmd_next;
        chan_reg     <= chan_next;
        req_reg      <= req_next;
        dur_reg      <= dur_next;
        cnt_reg      <= cnt_next;
        acc_reg      <= acc_next;
        first_reg    <= first_next;
        tick_adv_reg <= tick_adv_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Assertions
    a_enable_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        enabled_reg |=> enabled_reg)
        else $error("output enable dropped");

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        index_reg <= steps_reg)
        else $error("ramp index beyond step count");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_accept_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> m_tdata[17])
        else $error("accepted command without active output");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the servo pulse ramp generator: a directed table
// covers the corner cases, then several register settings are run with
// random move commands and frame ticks, each result checked in order.
// ----------------------------------------------------------------------------
module testbench;

    import sprg_pkg::*;

    localparam int PULSE_TOP   = 19999;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 100;
    localparam int PHASE_ITEMS = 75;
    localparam int NUM_PHASES  = 5;
    localparam int NUM_ROWS    = 26;

    typedef struct packed {
        logic               kind;
        logic [CHAN_W-1:0]  chan;
        logic [REQ_W-1:0]   req;
        logic [DUR_W-1:0]   dur;
        logic [PW_W-1:0]    cnt;
    } servo_item_t;

    typedef struct packed {
        logic            acc;
        logic [PW_W-1:0] pw;
        logic            pin;
        logic            act;
    } servo_result_t;

    typedef struct packed {
        servo_item_t   item;
        logic          typed;
        servo_result_t res;
    } dir_row_t;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [PW_W-1:0]   min_pw;
        logic [PW_W-1:0]   max_pw;
        logic [DUR_W-1:0]  min_dur;
        logic [DUR_W-1:0]  max_dur;
    } servo_cfg_t;

    // Directed items, run with the reset register values
    localparam dir_row_t DIRECTED [NUM_ROWS] = '{
        // ticks while disabled change nothing
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd0},     1'b1,
          '{1'b0, 15'd1500, 1'b0, 1'b0}},
        '{'{CMD_TICK, 8'd255, 16'd65535, 16'd65535, 15'd19999}, 1'b1,
          '{1'b0, 15'd1500, 1'b0, 1'b0}},
        // rejected: wrong channel, pulse below floor, above ceiling, all ones
        '{'{CMD_MOVE, 8'd1,   16'd1500,  16'd0,     15'd0},     1'b1,
          '{1'b0, 15'd1500, 1'b0, 1'b0}},
        '{'{CMD_MOVE, 8'd0,   16'd499,   16'd20,    15'd0},     1'b1,
          '{1'b0, 15'd1500, 1'b0, 1'b0}},
        '{'{CMD_MOVE, 8'd0,   16'd2501,  16'd20,    15'd0},     1'b1,
          '{1'b0, 15'd1500, 1'b0, 1'b0}},
        '{'{CMD_MOVE, 8'd255, 16'd65535, 16'd65535, 15'd19999}, 1'b1,
          '{1'b0, 15'd1500, 1'b0, 1'b0}},
        // first accepted move, zero duration: enables and jumps to target
        '{'{CMD_MOVE, 8'd0,   16'd2500,  16'd0,     15'd0},     1'b1,
          '{1'b1, 15'd2500, 1'b1, 1'b1}},
        // early tick raises the pin, late tick skips the frame
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd2499},  1'b1,
          '{1'b0, 15'd2500, 1'b1, 1'b1}},
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd2500},  1'b1,
          '{1'b0, 15'd2500, 1'b0, 1'b1}},
        // five-step ramp down, then one tick past its end
        '{'{CMD_MOVE, 8'd0,   16'd500,   16'd100,   15'd0},     1'b1,
          '{1'b1, 15'd2500, 1'b0, 1'b1}},
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd0},     1'b0, '0},
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd1000},  1'b0, '0},
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd2000},  1'b0, '0},
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd19999}, 1'b0, '0},
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd1300},  1'b0, '0},
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd0},     1'b0, '0},
        // three-step ramp up: truncated quotient
        '{'{CMD_MOVE, 8'd0,   16'd2500,  16'd60,    15'd0},     1'b1,
          '{1'b1, 15'd500, 1'b0, 1'b1}},
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd1165},  1'b0, '0},
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd1833},  1'b0, '0},
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd16384}, 1'b0, '0},
        // three-step ramp down, ceiling of 41/20: truncation toward zero
        '{'{CMD_MOVE, 8'd0,   16'd500,   16'd41,    15'd0},     1'b1,
          '{1'b1, 15'd2500, 1'b0, 1'b1}},
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd1834},  1'b0, '0},
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd1166},  1'b0, '0},
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd0},     1'b0, '0},
        // longest duration
        '{'{CMD_MOVE, 8'd0,   16'd2500,  16'd65535, 15'd0},     1'b1,
          '{1'b1, 15'd500, 1'b0, 1'b1}},
        '{'{CMD_TICK, 8'd0,   16'd0,     16'd0,     15'd499},   1'b0, '0}
    };

    // Register settings per random phase; extremes and inverted limits
    localparam servo_cfg_t PHASES [NUM_PHASES] = '{
        '{8'd255, 15'd0,     15'd19999, 16'd0,     16'd65535},
        '{8'd7,   15'd1000,  15'd2000,  16'd100,   16'd2000},
        '{8'd0,   15'd2000,  15'd1000,  16'd0,     16'd65535},
        '{8'd128, 15'd19999, 15'd19999, 16'd65535, 16'd65535},
        '{8'd3,   15'd300,   15'd2700,  16'd0,     16'd1000}
    };

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_A_W-1:0]    cfg_addr  = '0;
    logic [CFG_D_W-1:0]    cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // Predicted block state and register copy
    logic              srv_enabled;
    logic [PW_W-1:0]   srv_width;
    logic [PW_W-1:0]   srv_start;
    logic [PW_W-1:0]   srv_target;
    logic [STEPS_W-1:0] srv_steps;
    logic [STEPS_W-1:0] srv_index;
    logic [CHAN_W-1:0] cfg_chan   = 8'd0;
    logic [PW_W-1:0]   cfg_min_pw = 15'd500;
    logic [PW_W-1:0]   cfg_max_pw = 15'd2500;
    logic [DUR_W-1:0]  cfg_min_dur = 16'd0;
    logic [DUR_W-1:0]  cfg_max_dur = 16'd65535;

    servo_result_t pending_results [$];
    int            mismatches   = 0;
    int            results_seen = 0;
    bit            no_idle      = 1'b0;

    servo_pulse_ramp_generator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // One ramp step: interpolate and clamp, or settle on the target
    function automatic void step_ramp();
        int w;
        if (srv_index < srv_steps) begin
            srv_index = srv_index + 1'b1;
            w = int'(srv_start) +
                (int'(srv_target) - int'(srv_start)) * int'(srv_index) / int'(srv_steps);
            if (w < int'(cfg_min_pw)) begin
                w = int'(cfg_min_pw);
            end else if (w > int'(cfg_max_pw)) begin
                w = int'(cfg_max_pw);
            end
            srv_width = w[PW_W-1:0];
        end else begin
            srv_width = srv_target;
        end
    endfunction

    // Expected result of one item; updates the predicted state
    function automatic servo_result_t predict_servo(input servo_item_t it);
        servo_result_t r;
        int            steps;
        r = '0;
        if (it.kind == CMD_MOVE) begin
            if (it.chan == cfg_chan && it.req >= cfg_min_pw && it.req <= cfg_max_pw &&
                it.dur >= cfg_min_dur && it.dur <= cfg_max_dur) begin
                steps = (int'(it.dur) + FRAME_MS - 1) / FRAME_MS;
                if (steps > STEPS_MAX) begin
                    steps = STEPS_MAX;
                end
                r.acc      = 1'b1;
                srv_start  = srv_width;
                srv_target = it.req[PW_W-1:0];
                srv_steps  = steps[STEPS_W-1:0];
                srv_index  = '0;
                if (!srv_enabled) begin
                    srv_enabled = 1'b1;
                    step_ramp();
                    r.pin = 1'b1;
                end
            end
        end else if (srv_enabled) begin
            step_ramp();
            r.pin = (it.cnt < srv_width);
        end
        r.pw  = srv_width;
        r.act = srv_enabled;
        return r;
    endfunction

    // Random item: mostly valid moves and ticks, some near misses and noise
    function automatic servo_item_t random_item();
        servo_item_t it;
        int          pick;
        int          lo;
        int          hi;
        int          w;
        pick    = $urandom_range(0, 99);
        it.kind = CMD_TICK;
        it.chan = CHAN_W'($urandom);
        it.req  = REQ_W'($urandom);
        it.dur  = DUR_W'($urandom);
        it.cnt  = PW_W'($urandom_range(0, PULSE_TOP));
        if (pick < 30) begin
            it.kind = CMD_MOVE;
            it.chan = cfg_chan;
            it.req  = REQ_W'($urandom_range(int'(cfg_min_pw), int'(cfg_max_pw)));
            lo = int'(cfg_min_dur);
            hi = int'(cfg_max_dur);
            // short ramps mostly, so that they run to completion
            if (lo <= hi && hi > lo + 200 && $urandom_range(0, 7) != 0) begin
                hi = lo + 200;
            end
            it.dur = DUR_W'($urandom_range(lo, hi));
        end else if (pick < 82) begin
            // tick, often sampled right around the current width
            if ($urandom_range(0, 1) == 1) begin
                w = int'(srv_width) + int'($urandom_range(0, 4)) - 2;
                if (w < 0) begin
                    w = 0;
                end else if (w > PULSE_TOP) begin
                    w = PULSE_TOP;
                end
                it.cnt = w[PW_W-1:0];
            end
        end else if (pick < 92) begin
            // one field just past its limit
            it.kind = CMD_MOVE;
            it.chan = cfg_chan;
            it.req  = REQ_W'($urandom_range(int'(cfg_min_pw), int'(cfg_max_pw)));
            it.dur  = cfg_min_dur;
            case ($urandom_range(0, 2))
                0: it.req = REQ_W'(cfg_max_pw) + 1'b1;
                1: it.req = REQ_W'(cfg_min_pw) - 1'b1;
                default: it.dur = cfg_max_dur + 1'b1;
            endcase
        end else begin
            it.kind = CMD_MOVE;
        end
        return it;
    endfunction

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_CHANNEL_ID:   cfg_chan    = val[CHAN_W-1:0];
            REG_MIN_PULSE:    cfg_min_pw  = val[PW_W-1:0];
            REG_MAX_PULSE:    cfg_max_pw  = val[PW_W-1:0];
            REG_MIN_DURATION: cfg_min_dur = val;
            REG_MAX_DURATION: cfg_max_dur = val;
            default: ;
        endcase
    endtask

    // Random sender gap between items
    task automatic sender_gap();
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    // Offer one item, wait for the handshake, queue its expected result
    task automatic send_item(input servo_item_t it, input logic typed,
                             input servo_result_t typed_res);
        servo_result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {1'b0, it.cnt, it.dur, it.req, it.chan};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_servo(it);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Stimulus
    initial begin
        srv_enabled = 1'b0;
        srv_width   = PW_W'(NEUTRAL_PULSE);
        srv_start   = PW_W'(NEUTRAL_PULSE);
        srv_target  = PW_W'(NEUTRAL_PULSE);
        srv_steps   = '0;
        srv_index   = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            sender_gap();
            send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].res);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_reg(REG_CHANNEL_ID,   CFG_D_W'(PHASES[p].chan));
            write_reg(REG_MIN_PULSE,    CFG_D_W'(PHASES[p].min_pw));
            write_reg(REG_MAX_PULSE,    CFG_D_W'(PHASES[p].max_pw));
            write_reg(REG_MIN_DURATION, PHASES[p].min_dur);
            write_reg(REG_MAX_DURATION, PHASES[p].max_dur);
            // writes to unmapped indexes must leave everything alone
            for (int a = int'(REG_MAX_DURATION) + 1; a < (1 << CFG_A_W); a++) begin
                write_reg(CFG_A_W'(a), CFG_D_W'($urandom));
            end
            cfg_we <= 1'b0;
            no_idle = (p == NUM_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sender_gap();
                send_item(random_item(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off to back up the block
    initial begin : receiver
        bit held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!held && results_seen >= 40) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        servo_result_t got;
        servo_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.acc = m_tdata[0];
            got.pw  = m_tdata[15:1];
            got.pin = m_tdata[16];
            got.act = m_tdata[17];
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result item %0d: acc=%b pw=%0d pin=%b act=%b",
                             results_seen, got.acc, got.pw, got.pin, got.act);
                end
            end else begin
                want = pending_results.pop_front();
                if (got.acc !== want.acc || got.pw !== want.pw ||
                    got.pin !== want.pin || got.act !== want.act) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"result item %0d: expected acc=%b pw=%0d pin=%b act=%b,",
                                  " got acc=%b pw=%0d pin=%b act=%b"}, results_seen,
                                 want.acc, want.pw, want.pin, want.act,
                                 got.acc, got.pw, got.pin, got.act);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side
    initial begin : watchdog
        int still;
        still = 0;
        while (still < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                still = 0;
            end else begin
                still++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[servo_pulse_ramp_generator.f]
rtl/sprg_pkg.sv
rtl/sprg_serdiv.sv
rtl/servo_pulse_ramp_generator.sv
verif/testbench.sv
